// ===== sv/wfht_pkg.sv =====
// shared types, constants and register map of the window frame hit test block
package wfht_pkg;

    localparam int COORD_BITS = 16;
    // coordinate sums carry one extra bit so that nothing wraps
    localparam int CW = COORD_BITS + 1;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BORDER_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CAPTION_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CLOSE_SIZE     = 3'd2;
    localparam logic [2:0] REG_HANDLE_SIZE    = 3'd3;
    localparam logic [2:0] REG_BUTTON_MARGIN  = 3'd4;
    localparam logic [2:0] REG_CHROME_VISIBLE = 3'd5;

    localparam logic [7:0] RST_BORDER_WIDTH   = 8'd2;
    localparam logic [7:0] RST_CAPTION_HEIGHT = 8'd20;
    localparam logic [7:0] RST_CLOSE_SIZE     = 8'd16;
    localparam logic [7:0] RST_HANDLE_SIZE    = 8'd12;
    localparam logic [6:0] RST_BUTTON_MARGIN  = 7'd2;
    localparam logic       RST_CHROME_VISIBLE = 1'b1;

    typedef enum logic [2:0] {
        REGION_NONE    = 3'd0,
        REGION_CONTENT = 3'd1,
        REGION_CLOSE   = 3'd2,
        REGION_RESIZE  = 3'd3,
        REGION_TITLE   = 3'd4,
        REGION_BORDER  = 3'd5
    } t_region;

    typedef struct packed {
        logic [COORD_BITS-1:0] win_x;
        logic [COORD_BITS-1:0] win_y;
        logic [COORD_BITS-1:0] win_w;
        logic [COORD_BITS-1:0] win_h;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_item;

    typedef struct packed {
        logic [2:0]            region;
        logic [COORD_BITS-1:0] client_x;
        logic [COORD_BITS-1:0] client_y;
        logic [COORD_BITS-1:0] client_w;
        logic [COORD_BITS-1:0] client_h;
    } t_result;

    typedef struct packed {
        logic [7:0] border_width;
        logic [7:0] caption_height;
        logic [7:0] close_size;
        logic [7:0] handle_size;
        logic [6:0] button_margin;
        logic       chrome_visible;
    } t_cfg;

    // box as half-open span [x0,x1) x [y0,y1), vld low means empty
    typedef struct packed {
        logic          vld;
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } t_box;

    typedef struct packed {
        t_box                  outer;
        t_box                  title;
        t_box                  client;
        t_box                  closeb;
        t_box                  handle;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] client_x;
        logic [COORD_BITS-1:0] client_y;
        logic [COORD_BITS-1:0] client_w;
        logic [COORD_BITS-1:0] client_h;
    } t_geom;

endpackage

// ===== sv/wfht_geom.sv =====
// frame layout: outer, title, client, close button and resize handle boxes
module wfht_geom (
    input  wfht_pkg::t_cfg  i_cfg,
    input  wfht_pkg::t_item i_item,
    output wfht_pkg::t_geom o_geom
);
    import wfht_pkg::*;

    logic [CW-1:0]         x, y, w, h, xe, ye;
    logic [8:0]            bw2, tb;
    logic [7:0]            m2, tm, side_c, side_h, wh_min;
    logic [COORD_BITS-1:0] wm;
    logic                  win_ok, frame_ok, close_ok, handle_ok;
    logic [CW-1:0]         cx1, cy0, hx0, hy0;

    assign x  = {1'b0, i_item.win_x};
    assign y  = {1'b0, i_item.win_y};
    assign w  = {1'b0, i_item.win_w};
    assign h  = {1'b0, i_item.win_h};
    assign xe = x + w;
    assign ye = y + h;

    assign bw2 = {i_cfg.border_width, 1'b0};
    assign tb  = {1'b0, i_cfg.caption_height} + {1'b0, i_cfg.border_width};
    assign m2  = {i_cfg.button_margin, 1'b0};

    assign win_ok   = (i_item.win_w != '0) && (i_item.win_h != '0);
    assign frame_ok = win_ok && i_cfg.chrome_visible &&
                      (i_cfg.border_width != '0) && (i_cfg.caption_height != '0) &&
                      (w > CW'(bw2)) && (h > CW'(tb));

    // close button shrinks to fit the title bar less both margins
    assign close_ok = frame_ok && (i_cfg.close_size != '0) &&
                      (w > CW'(m2)) && (i_cfg.caption_height > m2);
    assign wm = i_item.win_w - COORD_BITS'(m2);
    assign tm = i_cfg.caption_height - m2;
    always_comb begin
        logic [7:0] lim;
        lim = (wm < COORD_BITS'(tm)) ? wm[7:0] : tm;
        side_c = (i_cfg.close_size < lim) ? i_cfg.close_size : lim;
    end
    assign cx1 = xe - CW'(i_cfg.button_margin);
    assign cy0 = y + CW'((i_cfg.caption_height - side_c) >> 1);

    // resize handle clipped to the window size
    assign handle_ok = frame_ok && (i_cfg.handle_size != '0);
    always_comb begin
        wh_min = i_cfg.handle_size;
        if (i_item.win_w < COORD_BITS'(wh_min)) begin
            wh_min = i_item.win_w[7:0];
        end
        if (i_item.win_h < COORD_BITS'(wh_min)) begin
            wh_min = i_item.win_h[7:0];
        end
        side_h = wh_min;
    end
    assign hx0 = xe - CW'(side_h);
    assign hy0 = ye - CW'(side_h);

    always_comb begin
        o_geom = '0;
        o_geom.point_x = i_item.point_x;
        o_geom.point_y = i_item.point_y;

        o_geom.outer = '{vld: win_ok, x0: x, y0: y, x1: xe, y1: ye};

        if (frame_ok) begin
            o_geom.title  = '{vld: 1'b1, x0: x, y0: y, x1: xe,
                              y1: y + CW'(i_cfg.caption_height)};
            o_geom.client = '{vld: 1'b1,
                              x0: x + CW'(i_cfg.border_width),
                              y0: y + CW'(i_cfg.caption_height),
                              x1: xe - CW'(i_cfg.border_width),
                              y1: ye - CW'(i_cfg.border_width)};
            o_geom.client_x = i_item.win_x + COORD_BITS'(i_cfg.border_width);
            o_geom.client_y = i_item.win_y + COORD_BITS'(i_cfg.caption_height);
            o_geom.client_w = i_item.win_w - COORD_BITS'(bw2);
            o_geom.client_h = i_item.win_h - COORD_BITS'(tb);
        end else if (win_ok && !i_cfg.chrome_visible) begin
            // hidden chrome: whole window is client
            o_geom.client   = o_geom.outer;
            o_geom.client_x = i_item.win_x;
            o_geom.client_y = i_item.win_y;
            o_geom.client_w = i_item.win_w;
            o_geom.client_h = i_item.win_h;
        end

        if (close_ok) begin
            o_geom.closeb = '{vld: 1'b1, x0: cx1 - CW'(side_c), y0: cy0,
                              x1: cx1, y1: cy0 + CW'(side_c)};
        end
        if (handle_ok) begin
            o_geom.handle = '{vld: 1'b1, x0: hx0, y0: hy0, x1: xe, y1: ye};
        end
    end

endmodule

// ===== sv/wfht_classify.sv =====
// point classification against the derived frame boxes
module wfht_classify (
    input  wfht_pkg::t_geom   i_geom,
    output wfht_pkg::t_region o_region
);
    import wfht_pkg::*;

    logic [CW-1:0] px, py;
    logic          in_outer, in_title, in_client, in_close, in_handle;

    function automatic logic hit(input t_box b, input logic [CW-1:0] qx,
                                 input logic [CW-1:0] qy);
        return b.vld && (qx >= b.x0) && (qx < b.x1) && (qy >= b.y0) && (qy < b.y1);
    endfunction

    assign px = {1'b0, i_geom.point_x};
    assign py = {1'b0, i_geom.point_y};

    assign in_outer  = hit(i_geom.outer,  px, py);
    assign in_title  = hit(i_geom.title,  px, py);
    assign in_client = hit(i_geom.client, px, py);
    assign in_close  = hit(i_geom.closeb, px, py);
    assign in_handle = hit(i_geom.handle, px, py);

    always_comb begin
        priority if (!in_outer) begin
            o_region = REGION_NONE;
        end else if (in_close) begin
            o_region = REGION_CLOSE;
        end else if (in_handle) begin
            o_region = REGION_RESIZE;
        end else if (in_client) begin
            o_region = REGION_CONTENT;
        end else if (in_title) begin
            o_region = REGION_TITLE;
        end else begin
            o_region = REGION_BORDER;
        end
    end

endmodule

// ===== sv/window_frame_hit_test_top.sv =====
// window frame hit test: top level with config registers and the item pipeline
//
//  channel   direction  handshake                    payload
//  item      in         start high, busy low         i_item   (wfht_pkg::t_item)
//  result    out        o_done one-cycle strobe      o_result (wfht_pkg::t_result)
//  config    in/out     apb psel/penable/pready      pwdata/prdata, 6 registers
//
//  an item is accepted every cycle while busy is low, and its result strobes
//  after three register stages: input, frame layout, classification
//  busy is high only while reset is asserted, no other stall exists
//  the receiver cannot stall: each result is shown for exactly one cycle
//  synchronous active-low reset clears the stage valids and restores register defaults
module window_frame_hit_test_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  wfht_pkg::t_item                      i_item,
    output logic                                 o_done,
    output wfht_pkg::t_result                    o_result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wfht_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [wfht_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [wfht_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import wfht_pkg::*;

    // configuration registers
    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    // stage 0: captured item
    logic       r_s0_vld;
    t_item      r_item;
    // stage 1: derived layout
    logic       r_s1_vld;
    t_geom      r_geom;
    t_geom      n_geom;
    // stage 2: classified result
    logic       r_done;
    t_result    r_result;
    t_region    n_region;
    logic       accept;

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // ---------------------------------------------------------------
    // apb register file, pready tied high
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.border_width   <= RST_BORDER_WIDTH;
            r_cfg.caption_height <= RST_CAPTION_HEIGHT;
            r_cfg.close_size     <= RST_CLOSE_SIZE;
            r_cfg.handle_size    <= RST_HANDLE_SIZE;
            r_cfg.button_margin  <= RST_BUTTON_MARGIN;
            r_cfg.chrome_visible <= RST_CHROME_VISIBLE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BORDER_WIDTH:   r_cfg.border_width   <= pwdata[7:0];
                REG_CAPTION_HEIGHT: r_cfg.caption_height <= pwdata[7:0];
                REG_CLOSE_SIZE:     r_cfg.close_size     <= pwdata[7:0];
                REG_HANDLE_SIZE:    r_cfg.handle_size    <= pwdata[7:0];
                REG_BUTTON_MARGIN:  r_cfg.button_margin  <= pwdata[6:0];
                REG_CHROME_VISIBLE: r_cfg.chrome_visible <= pwdata[0];
                default: ;  // writes beyond the map are dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BORDER_WIDTH:   prdata = APB_DATA_BITS'(r_cfg.border_width);
            REG_CAPTION_HEIGHT: prdata = APB_DATA_BITS'(r_cfg.caption_height);
            REG_CLOSE_SIZE:     prdata = APB_DATA_BITS'(r_cfg.close_size);
            REG_HANDLE_SIZE:    prdata = APB_DATA_BITS'(r_cfg.handle_size);
            REG_BUTTON_MARGIN:  prdata = APB_DATA_BITS'(r_cfg.button_margin);
            REG_CHROME_VISIBLE: prdata = APB_DATA_BITS'(r_cfg.chrome_visible);
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath: item register -> layout -> classification -> result
    // ---------------------------------------------------------------
    wfht_geom u_geom (
        .i_cfg  (r_cfg),
        .i_item (r_item),
        .o_geom (n_geom)
    );

    wfht_classify u_classify (
        .i_geom   (r_geom),
        .o_region (n_region)
    );

    // valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s0_vld <= accept;
            r_s1_vld <= r_s0_vld;
            r_done   <= r_s1_vld;
        end
    end

    // payload registers, loaded only when their stage carries a transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_s0_vld) begin
            r_geom <= n_geom;
        end
        if (r_s1_vld) begin
            r_result.region   <= n_region;
            r_result.client_x <= r_geom.client_x;
            r_result.client_y <= r_geom.client_y;
            r_result.client_w <= r_geom.client_w;
            r_result.client_h <= r_geom.client_h;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // every accepted item gives a result strobe on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("accepted item produced no result");

    // no result without an earlier accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 3)) |-> $past(accept, 3))
        else $error("result strobe without accepted item");

    // a close button hit needs a real client area
    a_close_client: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.region == REGION_CLOSE) |->
            (o_result.client_w != '0 && o_result.client_h != '0))
        else $error("close region reported on a degenerate frame");

    // a resize hit needs an enabled handle
    a_resize_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.region == REGION_RESIZE) |->
            (r_cfg.handle_size != '0 && r_cfg.chrome_visible))
        else $error("resize region reported with handle disabled");

endmodule
